/* rtl/sm83_row1_instruction_execute_core_defines.svh */
// ----------------------------------------------------------------------------
// SM83 execute core assertion macros
// Shared property forms for the checker of the execute core.
// ----------------------------------------------------------------------------
`ifndef SM83_ROW1_INSTRUCTION_EXECUTE_CORE_DEFINES_SVH
`define SM83_ROW1_INSTRUCTION_EXECUTE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SM83_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SM83_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sm83_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 execute package
// Opcode codes, flag positions, cycle counts, queued item and result formats.
// ----------------------------------------------------------------------------
package sm83_pkg;

	typedef enum logic [3:0] {
		OP_STOP   = 4'h0,
		OP_LD_DE  = 4'h1,
		OP_ST_DE  = 4'h2,
		OP_DE_INC = 4'h3,
		OP_D_INC  = 4'h4,
		OP_D_DEC  = 4'h5,
		OP_LD_D   = 4'h6,
		OP_RLA    = 4'h7,
		OP_JR     = 4'h8,
		OP_ADD_HL = 4'h9,
		OP_LD_A   = 4'hA,
		OP_DE_DEC = 4'hB,
		OP_E_INC  = 4'hC,
		OP_E_DEC  = 4'hD,
		OP_LD_E   = 4'hE,
		OP_RRA    = 4'hF
	} op_t;

	localparam int unsigned FLAG_Z = 3;
	localparam int unsigned FLAG_N = 2;
	localparam int unsigned FLAG_H = 1;
	localparam int unsigned FLAG_C = 0;

	localparam logic [3:0] CYCLES_SHORT = 4'd4;
	localparam logic [3:0] CYCLES_MID   = 4'd8;
	localparam logic [3:0] CYCLES_LONG  = 4'd12;

	typedef struct packed {
		op_t         op;
		logic [7:0]  operand_lo;
		logic [7:0]  operand_hi;
		logic [7:0]  read_data;
		logic [15:0] pc_delta;
		logic [3:0]  cycles;
	} uop_t;

	typedef struct packed {
		logic [7:0]  acc_value;
		logic [7:0]  d_value;
		logic [7:0]  e_value;
		logic [7:0]  h_value;
		logic [7:0]  l_value;
		logic [3:0]  flag_bits;
		logic [15:0] next_pc;
		logic        halted_by_stop;
		logic [15:0] bus_address;
		logic        bus_write;
		logic [7:0]  bus_data;
		logic [3:0]  cycle_count;
	} result_t;

endpackage

/* rtl/sm83_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 instruction channel
// Valid/ready channel that carries one instruction item.
// ----------------------------------------------------------------------------
interface sm83_in_if;
	logic       valid;
	logic       ready;
	logic [3:0] mode;
	logic [7:0] operand_lo;
	logic [7:0] operand_hi;
	logic [7:0] read_data;

	modport source (output valid, output mode, output operand_lo, output operand_hi,
		output read_data, input ready);
	modport sink (input valid, input mode, input operand_lo, input operand_hi,
		input read_data, output ready);
endinterface

/* rtl/sm83_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface sm83_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  acc_value;
	logic [7:0]  d_value;
	logic [7:0]  e_value;
	logic [7:0]  h_value;
	logic [7:0]  l_value;
	logic [3:0]  flag_bits;
	logic [15:0] next_pc;
	logic        halted_by_stop;
	logic [15:0] bus_address;
	logic        bus_write;
	logic [7:0]  bus_data;
	logic [3:0]  cycle_count;

	modport source (output valid, output acc_value, output d_value, output e_value,
		output h_value, output l_value, output flag_bits, output next_pc,
		output halted_by_stop, output bus_address, output bus_write, output bus_data,
		output cycle_count, input ready);
	modport sink (input valid, input acc_value, input d_value, input e_value,
		input h_value, input l_value, input flag_bits, input next_pc,
		input halted_by_stop, input bus_address, input bus_write, input bus_data,
		input cycle_count, output ready);
endinterface

/* rtl/sm83_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 front end
// Accepts instruction items, classifies the opcode and works out the cycle
// count and the program counter step before the item enters the queue.
// ----------------------------------------------------------------------------
module sm83_front (
	sm83_in_if.sink        instr,
	output logic           push_valid,
	input  logic           push_ready,
	output sm83_pkg::uop_t push_data
);

	sm83_pkg::op_t op;

	assign op = sm83_pkg::op_t'(instr.mode);

	assign instr.ready = push_ready;
	assign push_valid  = instr.valid;

	always_comb begin
		push_data.op         = op;
		push_data.operand_lo = instr.operand_lo;
		push_data.operand_hi = instr.operand_hi;
		push_data.read_data  = instr.read_data;
		push_data.pc_delta   = 16'd0;
		push_data.cycles     = sm83_pkg::CYCLES_SHORT;
		unique case (op)
			sm83_pkg::OP_STOP, sm83_pkg::OP_D_INC, sm83_pkg::OP_D_DEC,
			sm83_pkg::OP_E_INC, sm83_pkg::OP_E_DEC, sm83_pkg::OP_RLA,
			sm83_pkg::OP_RRA: begin
				push_data.cycles = sm83_pkg::CYCLES_SHORT;
			end
			sm83_pkg::OP_LD_DE: begin
				push_data.pc_delta = 16'd2;
				push_data.cycles   = sm83_pkg::CYCLES_LONG;
			end
			sm83_pkg::OP_LD_D, sm83_pkg::OP_LD_E: begin
				push_data.pc_delta = 16'd1;
				push_data.cycles   = sm83_pkg::CYCLES_MID;
			end
			sm83_pkg::OP_JR: begin
				push_data.pc_delta = {{8{instr.operand_lo[7]}}, instr.operand_lo} + 16'd1;
				push_data.cycles   = sm83_pkg::CYCLES_LONG;
			end
			sm83_pkg::OP_ST_DE, sm83_pkg::OP_DE_INC, sm83_pkg::OP_DE_DEC,
			sm83_pkg::OP_ADD_HL, sm83_pkg::OP_LD_A: begin
				push_data.cycles = sm83_pkg::CYCLES_MID;
			end
		endcase
	end

endmodule

/* rtl/sm83_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 instruction queue
// Small first-in first-out buffer of classified items between the front end
// and the execute back end. Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module sm83_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  sm83_pkg::uop_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output sm83_pkg::uop_t pop_data
);

	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	sm83_pkg::uop_t   entry_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/sm83_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 execute back end
// Holds the architectural registers, carries out one queued item per cycle
// unless a held result stalls, and puts its result in the output register.
// ----------------------------------------------------------------------------
module sm83_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  sm83_pkg::uop_t pop_data,
	sm83_out_if.source     result
);

	logic [7:0]        acc_q;
	logic [7:0]        reg_d_q;
	logic [7:0]        reg_e_q;
	logic [7:0]        reg_h_q;
	logic [7:0]        reg_l_q;
	logic [3:0]        flag_q;
	logic [15:0]       pc_q;
	logic              stop_q;
	logic              out_valid_q;
	sm83_pkg::result_t res_q;

	logic [7:0]        acc_n;
	logic [7:0]        d_n;
	logic [7:0]        e_n;
	logic [7:0]        h_n;
	logic [7:0]        l_n;
	logic [3:0]        flag_n;
	logic              stop_n;
	logic [15:0]       pc_n;
	logic [15:0]       de;
	logic [15:0]       de_inc;
	logic [15:0]       de_dec;
	logic [16:0]       hl_sum;
	logic [12:0]       hl_half;
	logic [7:0]        inc_val;
	logic [7:0]        dec_val;
	logic [7:0]        inc_src;
	logic [7:0]        dec_src;
	logic              fire;
	sm83_pkg::result_t res_n;

	assign pop_ready = !out_valid_q || result.ready;
	assign fire      = pop_valid && pop_ready;

	assign de      = {reg_d_q, reg_e_q};
	assign de_inc  = de + 16'd1;
	assign de_dec  = de - 16'd1;
	assign hl_sum  = {1'b0, reg_h_q, reg_l_q} + {1'b0, de};
	assign hl_half = {1'b0, reg_h_q[3:0], reg_l_q} + {1'b0, de[11:0]};
	assign pc_n    = pc_q + pop_data.pc_delta;
	assign inc_src = (pop_data.op == sm83_pkg::OP_E_INC) ? reg_e_q : reg_d_q;
	assign dec_src = (pop_data.op == sm83_pkg::OP_E_DEC) ? reg_e_q : reg_d_q;
	assign inc_val = inc_src + 8'd1;
	assign dec_val = dec_src - 8'd1;

	always_comb begin
		acc_n  = acc_q;
		d_n    = reg_d_q;
		e_n    = reg_e_q;
		h_n    = reg_h_q;
		l_n    = reg_l_q;
		flag_n = flag_q;
		stop_n = stop_q;
		res_n.bus_address = 16'd0;
		res_n.bus_write   = 1'b0;
		res_n.bus_data    = 8'd0;
		unique case (pop_data.op)
			sm83_pkg::OP_STOP: begin
				stop_n = 1'b1;
			end
			sm83_pkg::OP_LD_DE: begin
				d_n = pop_data.operand_hi;
				e_n = pop_data.operand_lo;
			end
			sm83_pkg::OP_ST_DE: begin
				res_n.bus_address = de;
				res_n.bus_write   = 1'b1;
				res_n.bus_data    = acc_q;
			end
			sm83_pkg::OP_DE_INC: begin
				{d_n, e_n} = de_inc;
			end
			sm83_pkg::OP_DE_DEC: begin
				{d_n, e_n} = de_dec;
			end
			sm83_pkg::OP_D_INC, sm83_pkg::OP_E_INC: begin
				if (pop_data.op == sm83_pkg::OP_D_INC) begin
					d_n = inc_val;
				end else begin
					e_n = inc_val;
				end
				flag_n[sm83_pkg::FLAG_Z] = (inc_val == 8'd0);
				flag_n[sm83_pkg::FLAG_N] = 1'b0;
				flag_n[sm83_pkg::FLAG_H] = (inc_src[3:0] == 4'hF);
			end
			sm83_pkg::OP_D_DEC, sm83_pkg::OP_E_DEC: begin
				if (pop_data.op == sm83_pkg::OP_D_DEC) begin
					d_n = dec_val;
				end else begin
					e_n = dec_val;
				end
				flag_n[sm83_pkg::FLAG_Z] = (dec_val == 8'd0);
				flag_n[sm83_pkg::FLAG_N] = 1'b1;
				flag_n[sm83_pkg::FLAG_H] = (dec_src[3:0] == 4'h0);
			end
			sm83_pkg::OP_LD_D: begin
				d_n = pop_data.operand_lo;
			end
			sm83_pkg::OP_LD_E: begin
				e_n = pop_data.operand_lo;
			end
			sm83_pkg::OP_RLA: begin
				acc_n  = {acc_q[6:0], flag_q[sm83_pkg::FLAG_C]};
				flag_n = {3'b000, acc_q[7]};
			end
			sm83_pkg::OP_RRA: begin
				acc_n  = {flag_q[sm83_pkg::FLAG_C], acc_q[7:1]};
				flag_n = {3'b000, acc_q[0]};
			end
			sm83_pkg::OP_JR: begin
				stop_n = stop_q;
			end
			sm83_pkg::OP_ADD_HL: begin
				{h_n, l_n} = hl_sum[15:0];
				flag_n[sm83_pkg::FLAG_N] = 1'b0;
				flag_n[sm83_pkg::FLAG_H] = hl_half[12];
				flag_n[sm83_pkg::FLAG_C] = hl_sum[16];
			end
			sm83_pkg::OP_LD_A: begin
				acc_n             = pop_data.read_data;
				res_n.bus_address = de;
			end
		endcase
		res_n.acc_value      = acc_n;
		res_n.d_value        = d_n;
		res_n.e_value        = e_n;
		res_n.h_value        = h_n;
		res_n.l_value        = l_n;
		res_n.flag_bits      = flag_n;
		res_n.next_pc        = pc_n;
		res_n.halted_by_stop = stop_n;
		res_n.cycle_count    = pop_data.cycles;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			reg_d_q     <= '0;
			reg_e_q     <= '0;
			reg_h_q     <= '0;
			reg_l_q     <= '0;
			flag_q      <= '0;
			pc_q        <= '0;
			stop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				acc_q   <= acc_n;
				reg_d_q <= d_n;
				reg_e_q <= e_n;
				reg_h_q <= h_n;
				reg_l_q <= l_n;
				flag_q  <= flag_n;
				pc_q    <= pc_n;
				stop_q  <= stop_n;
			end
			if (pop_ready) begin
				out_valid_q <= pop_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_n;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.acc_value      = res_q.acc_value;
	assign result.d_value        = res_q.d_value;
	assign result.e_value        = res_q.e_value;
	assign result.h_value        = res_q.h_value;
	assign result.l_value        = res_q.l_value;
	assign result.flag_bits      = res_q.flag_bits;
	assign result.next_pc        = res_q.next_pc;
	assign result.halted_by_stop = res_q.halted_by_stop;
	assign result.bus_address    = res_q.bus_address;
	assign result.bus_write      = res_q.bus_write;
	assign result.bus_data       = res_q.bus_data;
	assign result.cycle_count    = res_q.cycle_count;

endmodule

/* rtl/sm83_row1_instruction_execute_core.sv */
// An accepted item is registered in the queue, then in the output register.
// Throughput: one item per cycle while the result channel is ready; the back
// end's register update lands as each item pops, so no item waits on another.
// The input stalls only when the instruction queue is full.
// Reset clears all registers, flags, program counter, stop latch and queue.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 row 1 instruction execute core
// Executes opcodes 0x10 to 0x1F: a front end classifies items, a queue
// decouples it from the back end, which updates the registers.
// ----------------------------------------------------------------------------
module sm83_row1_instruction_execute_core #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	sm83_in_if.sink    instr,
	sm83_out_if.source result
);

	logic           push_valid;
	logic           push_ready;
	sm83_pkg::uop_t push_data;
	logic           pop_valid;
	logic           pop_ready;
	sm83_pkg::uop_t pop_data;

	sm83_front u_front (
		.instr      (instr),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	sm83_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	sm83_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.result    (result)
	);

endmodule

/* rtl/sm83_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 execute core checker
// Watches the result port of the execute core over time.
// ----------------------------------------------------------------------------
`include "sm83_row1_instruction_execute_core_defines.svh"

module sm83_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  acc_value,
	input logic [7:0]  d_value,
	input logic [7:0]  e_value,
	input logic        halted_by_stop,
	input logic [15:0] bus_address,
	input logic        bus_write,
	input logic [7:0]  bus_data,
	input logic [3:0]  cycle_count
);

	`SM83_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready, out_valid && $stable(cycle_count) && $stable(bus_address), "Stalled result item changed.")
	`SM83_ASSERT_NOW(a_cycle_legal, out_valid, cycle_count == 4'd4 || cycle_count == 4'd8 || cycle_count == 4'd12, "Illegal cycle count.")
	`SM83_ASSERT_NOW(a_store_bus, out_valid && bus_write, bus_address == {d_value, e_value} && bus_data == acc_value && cycle_count == 4'd8, "Store bus access does not match DE and A.")
	`SM83_ASSERT_NEXT(a_stop_sticky, out_valid && halted_by_stop, !out_valid || halted_by_stop, "Stop latch cleared without reset.")

endmodule

bind sm83_row1_instruction_execute_core sm83_checker u_sm83_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.acc_value      (result.acc_value),
	.d_value        (result.d_value),
	.e_value        (result.e_value),
	.halted_by_stop (result.halted_by_stop),
	.bus_address    (result.bus_address),
	.bus_write      (result.bus_write),
	.bus_data       (result.bus_data),
	.cycle_count    (result.cycle_count)
);

/* dv/sm83_row1_instruction_execute_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 row 1 execute checker
// Watches the instruction and result channels of the execute core. It keeps
// its own copy of the register file, flags, program counter and stop latch,
// predicts one result for every accepted instruction, and compares each
// accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sm83_row1_instruction_execute_checker (
	input  logic clk,
	input  logic arst_n,
	sm83_in_if   instr,
	sm83_out_if  result,
	output int   mismatches,
	output int   outstanding
);

	logic [7:0]  model_a;
	logic [7:0]  model_d;
	logic [7:0]  model_e;
	logic [7:0]  model_h;
	logic [7:0]  model_l;
	logic [3:0]  model_flags;
	logic [15:0] model_pc;
	logic        model_stopped;

	sm83_pkg::result_t pending_results[$];

	function automatic sm83_pkg::result_t execute_row1(input sm83_pkg::op_t op,
		input logic [7:0] lo, input logic [7:0] hi, input logic [7:0] rd);
		sm83_pkg::result_t res;
		logic [15:0]       de;
		logic [15:0]       hl;
		logic [16:0]       sum;
		logic [12:0]       low_sum;
		logic              carry_in;
		logic [7:0]        val;

		de = {model_d, model_e};
		hl = {model_h, model_l};
		carry_in = model_flags[sm83_pkg::FLAG_C];
		res = '0;
		res.cycle_count = sm83_pkg::CYCLES_SHORT;
		case (op)
			sm83_pkg::OP_STOP: begin
				model_stopped = 1'b1;
			end
			sm83_pkg::OP_LD_DE: begin
				model_d = hi;
				model_e = lo;
				model_pc = model_pc + 16'd2;
				res.cycle_count = sm83_pkg::CYCLES_LONG;
			end
			sm83_pkg::OP_ST_DE: begin
				res.bus_address = de;
				res.bus_write = 1'b1;
				res.bus_data = model_a;
				res.cycle_count = sm83_pkg::CYCLES_MID;
			end
			sm83_pkg::OP_DE_INC, sm83_pkg::OP_DE_DEC: begin
				de = (op == sm83_pkg::OP_DE_INC) ? de + 16'd1 : de - 16'd1;
				{model_d, model_e} = de;
				res.cycle_count = sm83_pkg::CYCLES_MID;
			end
			sm83_pkg::OP_D_INC, sm83_pkg::OP_E_INC: begin
				val = (op == sm83_pkg::OP_D_INC) ? model_d : model_e;
				model_flags[sm83_pkg::FLAG_H] = (val[3:0] == 4'hF);
				val = val + 8'd1;
				model_flags[sm83_pkg::FLAG_Z] = (val == 8'd0);
				model_flags[sm83_pkg::FLAG_N] = 1'b0;
				if (op == sm83_pkg::OP_D_INC) begin
					model_d = val;
				end else begin
					model_e = val;
				end
			end
			sm83_pkg::OP_D_DEC, sm83_pkg::OP_E_DEC: begin
				val = (op == sm83_pkg::OP_D_DEC) ? model_d : model_e;
				model_flags[sm83_pkg::FLAG_H] = (val[3:0] == 4'h0);
				val = val - 8'd1;
				model_flags[sm83_pkg::FLAG_Z] = (val == 8'd0);
				model_flags[sm83_pkg::FLAG_N] = 1'b1;
				if (op == sm83_pkg::OP_D_DEC) begin
					model_d = val;
				end else begin
					model_e = val;
				end
			end
			sm83_pkg::OP_LD_D: begin
				model_d = lo;
				model_pc = model_pc + 16'd1;
				res.cycle_count = sm83_pkg::CYCLES_MID;
			end
			sm83_pkg::OP_LD_E: begin
				model_e = lo;
				model_pc = model_pc + 16'd1;
				res.cycle_count = sm83_pkg::CYCLES_MID;
			end
			sm83_pkg::OP_RLA: begin
				model_flags = '0;
				model_flags[sm83_pkg::FLAG_C] = model_a[7];
				model_a = {model_a[6:0], carry_in};
			end
			sm83_pkg::OP_RRA: begin
				model_flags = '0;
				model_flags[sm83_pkg::FLAG_C] = model_a[0];
				model_a = {carry_in, model_a[7:1]};
			end
			sm83_pkg::OP_JR: begin
				model_pc = model_pc + 16'd1 + {{8{lo[7]}}, lo};
				res.cycle_count = sm83_pkg::CYCLES_LONG;
			end
			sm83_pkg::OP_ADD_HL: begin
				sum = {1'b0, hl} + {1'b0, de};
				low_sum = {1'b0, hl[11:0]} + {1'b0, de[11:0]};
				model_flags[sm83_pkg::FLAG_N] = 1'b0;
				model_flags[sm83_pkg::FLAG_H] = low_sum[12];
				model_flags[sm83_pkg::FLAG_C] = sum[16];
				{model_h, model_l} = sum[15:0];
				res.cycle_count = sm83_pkg::CYCLES_MID;
			end
			sm83_pkg::OP_LD_A: begin
				model_a = rd;
				res.bus_address = de;
				res.cycle_count = sm83_pkg::CYCLES_MID;
			end
			default: begin
			end
		endcase
		res.acc_value = model_a;
		res.d_value = model_d;
		res.e_value = model_e;
		res.h_value = model_h;
		res.l_value = model_l;
		res.flag_bits = model_flags;
		res.next_pc = model_pc;
		res.halted_by_stop = model_stopped;
		return res;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		mismatches = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		sm83_pkg::result_t want;

		if (!arst_n) begin
			model_a = '0;
			model_d = '0;
			model_e = '0;
			model_h = '0;
			model_l = '0;
			model_flags = '0;
			model_pc = '0;
			model_stopped = 1'b0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (result.valid === 1'b1 && result.ready === 1'b1) begin
				if (pending_results.size() == 0) begin
					$error("result item arrived with no instruction outstanding");
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("acc_value", want.acc_value, result.acc_value);
					check_field("d_value", want.d_value, result.d_value);
					check_field("e_value", want.e_value, result.e_value);
					check_field("h_value", want.h_value, result.h_value);
					check_field("l_value", want.l_value, result.l_value);
					check_field("flag_bits", want.flag_bits, result.flag_bits);
					check_field("next_pc", want.next_pc, result.next_pc);
					check_field("halted_by_stop", want.halted_by_stop,
						result.halted_by_stop);
					check_field("bus_address", want.bus_address, result.bus_address);
					check_field("bus_write", want.bus_write, result.bus_write);
					check_field("bus_data", want.bus_data, result.bus_data);
					check_field("cycle_count", want.cycle_count, result.cycle_count);
				end
			end
			if (instr.valid === 1'b1 && instr.ready === 1'b1) begin
				pending_results.push_back(execute_row1(sm83_pkg::op_t'(instr.mode),
					instr.operand_lo, instr.operand_hi, instr.read_data));
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

/* dv/tb_sm83_row1_instruction_execute_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 row 1 execute core testbench
// Drives a directed set of instructions that hits register and program
// counter wrap, half carry and carry edges, the stop latch and every opcode,
// then about 1800 random instructions with random idle bursts on both
// channels. A checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sm83_row1_instruction_execute_core;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   send_gap_pct;
	int   recv_stall_pct;

	sm83_in_if  instr_ch ();
	sm83_out_if result_ch ();

	sm83_row1_instruction_execute_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.result (result_ch)
	);

	sm83_row1_instruction_execute_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr       (instr_ch),
		.result      (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h7F;
			3: return 8'h80;
			4: return {4'($urandom_range(15)), 4'hF};
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_item(input sm83_pkg::op_t op, input logic [7:0] lo,
		input logic [7:0] hi, input logic [7:0] rd);
		int gap;

		instr_ch.valid <= 1'b1;
		instr_ch.mode <= op;
		instr_ch.operand_lo <= lo;
		instr_ch.operand_hi <= hi;
		instr_ch.read_data <= rd;
		@(posedge clk);
		while (instr_ch.ready !== 1'b1) @(posedge clk);
		if ($urandom_range(99) < send_gap_pct) begin
			gap = $urandom_range(1, 8);
			instr_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int stall_left;

		stall_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(99) < recv_stall_pct) begin
				result_ch.ready <= 1'b0;
				stall_left = $urandom_range(1, 8) - 1;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int wait_cycles;

		send_gap_pct = 20;
		recv_stall_pct = 20;
		arst_n <= 1'b0;
		instr_ch.valid <= 1'b0;
		instr_ch.mode <= sm83_pkg::OP_STOP;
		instr_ch.operand_lo <= '0;
		instr_ch.operand_hi <= '0;
		instr_ch.read_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(sm83_pkg::OP_DE_DEC, 8'($urandom), 8'($urandom), 8'($urandom));
		send_item(sm83_pkg::OP_DE_INC, 8'($urandom), 8'($urandom), 8'($urandom));
		send_item(sm83_pkg::OP_JR, 8'h80, 8'($urandom), 8'($urandom));
		send_item(sm83_pkg::OP_JR, 8'h7F, 8'($urandom), 8'($urandom));
		send_item(sm83_pkg::OP_LD_DE, 8'hFF, 8'hFF, 8'($urandom));
		send_item(sm83_pkg::OP_D_INC, 8'($urandom), 8'($urandom), 8'($urandom));
		send_item(sm83_pkg::OP_E_DEC, 8'($urandom), 8'($urandom), 8'($urandom));
		send_item(sm83_pkg::OP_E_INC, 8'($urandom), 8'($urandom), 8'($urandom));
		send_item(sm83_pkg::OP_E_INC, 8'($urandom), 8'($urandom), 8'($urandom));
		send_item(sm83_pkg::OP_D_DEC, 8'($urandom), 8'($urandom), 8'($urandom));
		send_item(sm83_pkg::OP_ADD_HL, 8'($urandom), 8'($urandom), 8'($urandom));
		send_item(sm83_pkg::OP_ADD_HL, 8'($urandom), 8'($urandom), 8'($urandom));
		send_item(sm83_pkg::OP_LD_A, 8'($urandom), 8'($urandom), 8'hFF);
		send_item(sm83_pkg::OP_RLA, 8'($urandom), 8'($urandom), 8'($urandom));
		send_item(sm83_pkg::OP_RRA, 8'($urandom), 8'($urandom), 8'($urandom));
		send_item(sm83_pkg::OP_ST_DE, 8'($urandom), 8'($urandom), 8'($urandom));
		send_item(sm83_pkg::OP_LD_D, 8'h00, 8'($urandom), 8'($urandom));
		send_item(sm83_pkg::OP_LD_E, 8'h80, 8'($urandom), 8'($urandom));
		send_item(sm83_pkg::OP_STOP, 8'hFF, 8'hFF, 8'hFF);
		send_item(sm83_pkg::OP_RLA, 8'($urandom), 8'($urandom), 8'($urandom));
		send_item(sm83_pkg::OP_LD_A, 8'($urandom), 8'($urandom), 8'h00);
		send_item(sm83_pkg::OP_ST_DE, 8'($urandom), 8'($urandom), 8'($urandom));
		send_item(sm83_pkg::OP_JR, 8'h00, 8'($urandom), 8'($urandom));
		send_item(sm83_pkg::OP_LD_DE, 8'h00, 8'h00, 8'($urandom));
		send_item(sm83_pkg::OP_STOP, 8'h00, 8'h00, 8'h00);

		for (int blk = 0; blk < 9; blk++) begin
			if (blk == 8) begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end else begin
				send_gap_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 50);
				recv_stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 50);
			end
			for (int n = 0; n < 200; n++) begin
				send_item(sm83_pkg::op_t'($urandom_range(15)), pick_byte(), pick_byte(),
					pick_byte());
			end
		end
		instr_ch.valid <= 1'b0;

		wait_cycles = 0;
		while (outstanding != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
